// ===== rtl/sst_pkg.sv =====
// Shared types, constants and codes for the sorted set table.
package sst_pkg;

   // Number of cells in the chain (maximum number of held values)
   localparam int CAPACITY = 16;
   // Width of the held count, able to hold CAPACITY itself
   localparam int CNT_W = $clog2(CAPACITY + 1);
   // Width of the count field in the response word
   localparam int RSP_CNT_W = 5;
   localparam int VALUE_W = 32;

   // Command codes
   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // Request word
   typedef struct packed {
      logic                      command;
      logic signed [VALUE_W-1:0] value;
   } sst_req_type;

   // Response word
   typedef struct packed {
      logic                 changed;
      logic                 full_refused;
      logic [RSP_CNT_W-1:0] entry_count;
   } sst_rsp_type;

   // Broadcast control to every cell
   typedef struct packed {
      logic                      add_en;
      logic                      rem_en;
      logic signed [VALUE_W-1:0] value;
   } sst_ctl_type;

   // Contents of one cell as seen by its neighbors
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
   } sst_slot_type;

endpackage

// ===== rtl/sst_cell.sv =====
// One cell of the sorted chain: holds one entry and shifts with its neighbors.
module sst_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  sst_pkg::sst_ctl_type  ctl,
   input  sst_pkg::sst_slot_type left_slot,
   input  logic                  left_lt,
   input  sst_pkg::sst_slot_type right_slot,
   output sst_pkg::sst_slot_type slot,
   output logic                  lt,
   output logic                  eq
);

   logic                      valid_ff;
   logic                      valid_in;
   logic signed [sst_pkg::VALUE_W-1:0] value_ff;
   logic signed [sst_pkg::VALUE_W-1:0] value_in;

   // Compare held entry against the broadcast value; empty cells act as +infinity
   assign lt = valid_ff && ($signed(value_ff) < $signed(ctl.value));
   assign eq = valid_ff && (value_ff == ctl.value);

   // Next contents: keep if below the value, else insert or shift
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctl.add_en && !lt) begin
         if (left_lt) begin
            valid_in = 1'b1;
            value_in = ctl.value;
         end else begin
            valid_in = left_slot.valid;
            value_in = left_slot.value;
         end
      end else if (ctl.rem_en && !lt) begin
         valid_in = right_slot.valid;
         value_in = right_slot.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Entry payload needs no reset
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign slot.valid = valid_ff;
   assign slot.value = value_ff;

endmodule

// ===== rtl/sorted_set_table_core.sv =====
// Sorted set table: a chain of compare-and-shift cells holding distinct values.
//
// Holds up to sst_pkg::CAPACITY distinct signed 32-bit values in ascending
// order, one per cell. A word is taken on every clock edge with start high
// (busy is always low), so one add or remove per cycle is sustained. Every
// cell compares its entry with the word's value at once and inserts, shifts
// or holds in that same cycle; the response word appears on rsp_word with
// rsp_strobe high for exactly one cycle, the cycle after the word is taken.
// The receiver cannot stall the block, so it must capture each response in
// its strobe cycle. Reset clears every valid bit, the held count and the strobe.
module sorted_set_table_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  sst_pkg::sst_req_type req_word,
   output logic                 rsp_strobe,
   output sst_pkg::sst_rsp_type rsp_word
);

   sst_pkg::sst_ctl_type  ctl;
   sst_pkg::sst_slot_type slots   [sst_pkg::CAPACITY];
   sst_pkg::sst_slot_type empty_slot;
   logic [sst_pkg::CAPACITY-1:0] lt_vec;
   logic [sst_pkg::CAPACITY-1:0] eq_vec;
   logic [sst_pkg::CAPACITY-1:0] valid_vec;
   logic [sst_pkg::CAPACITY-1:0] valid_expect;

   logic [sst_pkg::CNT_W-1:0] count_ff;
   logic [sst_pkg::CNT_W-1:0] count_in;
   logic                      rsp_strobe_ff;
   sst_pkg::sst_rsp_type      rsp_word_ff;
   sst_pkg::sst_rsp_type      rsp_word_in;

   logic accept;
   logic found;
   logic full;
   logic is_add;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign found  = |eq_vec;
   assign full   = (count_ff == sst_pkg::CNT_W'(sst_pkg::CAPACITY));
   assign is_add = (req_word.command == sst_pkg::CMD_ADD);

   // Broadcast control to the chain
   assign ctl.add_en = accept && is_add && !found && !full;
   assign ctl.rem_en = accept && (req_word.command == sst_pkg::CMD_REMOVE) && found;
   assign ctl.value  = req_word.value;

   assign empty_slot.valid = 1'b0;
   assign empty_slot.value = '0;

   // Chain of cells; ends see an empty neighbor
   for (genvar i = 0; i < sst_pkg::CAPACITY; i++) begin : g_cell
      sst_pkg::sst_slot_type left_slot;
      sst_pkg::sst_slot_type right_slot;
      logic                  left_lt;

      if (i == 0) begin : g_first
         assign left_slot = empty_slot;
         assign left_lt   = 1'b1;
      end else begin : g_mid
         assign left_slot = slots[i-1];
         assign left_lt   = lt_vec[i-1];
      end

      if (i == sst_pkg::CAPACITY - 1) begin : g_last
         assign right_slot = empty_slot;
      end else begin : g_inner
         assign right_slot = slots[i+1];
      end

      sst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .left_slot  (left_slot),
         .left_lt    (left_lt),
         .right_slot (right_slot),
         .slot       (slots[i]),
         .lt         (lt_vec[i]),
         .eq         (eq_vec[i])
      );

      assign valid_vec[i]    = slots[i].valid;
      assign valid_expect[i] = (sst_pkg::CNT_W'(i) < count_ff);
   end

   // Count update and response word
   always_comb begin
      count_in = count_ff;
      if (ctl.add_en) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.rem_en) begin
         count_in = count_ff - 1'b1;
      end
      rsp_word_in.changed      = ctl.add_en || ctl.rem_en;
      rsp_word_in.full_refused = accept && is_add && !found && full;
      rsp_word_in.entry_count  = sst_pkg::RSP_CNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   // Response payload needs no reset
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // Held count never passes the chain length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sst_pkg::CNT_W'(sst_pkg::CAPACITY))
      else $error("held count above capacity");

   // Occupied cells are exactly the lowest count cells
   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      valid_vec == valid_expect)
      else $error("cell valid bits disagree with held count");

   // Each taken word gives one response in the next cycle, no others
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("missing response");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("response without a word");

   // A refusal never coincides with a change
   a_refuse_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_word.changed && rsp_word.full_refused))
      else $error("refused and changed together");

endmodule

// ===== test/sorted_set_table_core_tb.sv =====
// Self-checking testbench for sorted_set_table_core: adds and removes words against a shadow set.
module sorted_set_table_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SHOWN_ERRORS = 10;
   localparam logic signed [sst_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [sst_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   sst_pkg::sst_req_type req_word = '0;
   logic                 rsp_strobe;
   sst_pkg::sst_rsp_type rsp_word;

   // Shadow copy of the block's contents, updated when a word is accepted
   logic signed [sst_pkg::VALUE_W-1:0] shadow_set [sst_pkg::CAPACITY];
   int                                 shadow_count = 0;
   sst_pkg::sst_rsp_type               pending_rsp_q [$];
   int                                 error_count = 0;
   int                                 cycle_count = 0;
   int                                 burst_left = 0;

   sorted_set_table_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one word to the shadow set and return the response it must produce
   function automatic sst_pkg::sst_rsp_type apply_to_shadow(sst_pkg::sst_req_type w);
      sst_pkg::sst_rsp_type rsp;
      int                   slot;
      logic                 present;
      rsp = '0;
      slot = shadow_count;
      for (int i = shadow_count - 1; i >= 0; i--)
         if (shadow_set[i] >= w.value) slot = i;
      present = (slot < shadow_count) && (shadow_set[slot] == w.value);
      if (w.command == sst_pkg::CMD_ADD) begin
         if (!present) begin
            if (shadow_count >= sst_pkg::CAPACITY) begin
               rsp.full_refused = 1'b1;
            end else begin
               for (int i = shadow_count; i > slot; i--) shadow_set[i] = shadow_set[i-1];
               shadow_set[slot] = w.value;
               shadow_count++;
               rsp.changed = 1'b1;
            end
         end
      end else if (present) begin
         for (int i = slot; i + 1 < shadow_count; i++) shadow_set[i] = shadow_set[i+1];
         shadow_count--;
         rsp.changed = 1'b1;
      end
      rsp.entry_count = sst_pkg::RSP_CNT_W'(shadow_count);
      return rsp;
   endfunction

   task automatic report_mismatch(string field, logic [sst_pkg::VALUE_W-1:0] exp_v,
                                  logic [sst_pkg::VALUE_W-1:0] act_v);
      error_count++;
      if (error_count <= SHOWN_ERRORS)
         $display("mismatch at cycle %0d: %s expected %0h got %0h",
                  cycle_count, field, exp_v, act_v);
   endtask

   // Response checker: every strobe must match the oldest pending expectation
   always @(posedge clock) begin
      sst_pkg::sst_rsp_type exp_rsp;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("unexpected response", '0, rsp_word);
         end else begin
            exp_rsp = pending_rsp_q.pop_front();
            if (rsp_word.changed !== exp_rsp.changed)
               report_mismatch("changed", exp_rsp.changed, rsp_word.changed);
            if (rsp_word.full_refused !== exp_rsp.full_refused)
               report_mismatch("full_refused", exp_rsp.full_refused, rsp_word.full_refused);
            if (rsp_word.entry_count !== exp_rsp.entry_count)
               report_mismatch("entry_count", exp_rsp.entry_count, rsp_word.entry_count);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Sender pacing: bursts of random length, short gaps between them
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(7) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
         gap = $urandom_range(5, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drive one word and hold it until taken; predict on acceptance
   task automatic send_word(input logic cmd, input logic signed [sst_pkg::VALUE_W-1:0] val);
      sst_pkg::sst_req_type w;
      w.command = cmd;
      w.value = val;
      req_word <= w;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      pending_rsp_q.push_back(apply_to_shadow(w));
      pace_sender();
   endtask

   // Range extremes, duplicate add, absent remove, removal at both ends
   task automatic test_extremes();
      send_word(sst_pkg::CMD_ADD, VALUE_MIN);
      send_word(sst_pkg::CMD_ADD, VALUE_MAX);
      send_word(sst_pkg::CMD_ADD, 32'sd0);
      send_word(sst_pkg::CMD_ADD, -32'sd1);
      send_word(sst_pkg::CMD_ADD, 32'sd1);
      send_word(sst_pkg::CMD_ADD, 32'sd0);
      send_word(sst_pkg::CMD_REMOVE, 32'sd5);
      send_word(sst_pkg::CMD_REMOVE, VALUE_MIN);
      send_word(sst_pkg::CMD_REMOVE, VALUE_MAX);
   endtask

   // Fill to capacity, then a refused add and a duplicate add on a full table
   task automatic test_full_table();
      for (int k = 2; k <= 14; k++)
         send_word(sst_pkg::CMD_ADD, (k % 2) ? -(k * 1000) : k * 1000);
      send_word(sst_pkg::CMD_ADD, 32'sd12345);
      send_word(sst_pkg::CMD_ADD, 32'sd2000);
   endtask

   // Random traffic: phases alternate between filling and draining the table; the last phase is balanced
   task automatic test_random_traffic();
      logic signed [sst_pkg::VALUE_W-1:0] pool [24];
      logic signed [sst_pkg::VALUE_W-1:0] val;
      logic                               cmd;
      int                                 add_pct;
      int                                 sel;
      for (int phase = 0; phase < 12; phase++) begin
         foreach (pool[i]) pool[i] = $urandom;
         pool[0] = VALUE_MIN;
         pool[1] = VALUE_MAX;
         pool[2] = 32'sd0;
         pool[3] = -32'sd1;
         pool[5] = pool[4] + 1;
         pool[7] = pool[6] - 1;
         add_pct = (phase == 11) ? 50 : (phase % 2) ? 25 : 75;
         for (int n = 0; n < 120; n++) begin
            cmd = ($urandom_range(99) < add_pct) ? sst_pkg::CMD_ADD : sst_pkg::CMD_REMOVE;
            sel = $urandom_range(9);
            if (cmd == sst_pkg::CMD_REMOVE && shadow_count > 0 && sel < 5)
               val = shadow_set[$urandom_range(shadow_count - 1)];
            else if (sel < 8)
               val = pool[$urandom_range(23)];
            else
               val = $urandom;
            send_word(cmd, val);
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_full_table();
      test_random_traffic();
      start <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
